// ----- rtl/afic_pkg.sv -----
`timescale 1ns / 1ps
package afic_pkg;

	// default frame capacity in samples
	localparam int MAX_FRAME_SAMPLES_DEF = 512;

	// entries in the queue between classification and verdict
	localparam int QUEUE_DEPTH = 4;

	// result bus width: 164 payload bits padded to whole bytes
	localparam int OUT_DATA_W = 168;

	// result kind on tuser
	localparam logic KIND_SAMPLE  = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	typedef enum logic [2:0] {
		ST_ACCEPTED  = 3'd0,
		ST_DISABLED  = 3'd1,
		ST_BAD_LEN   = 3'd2,
		ST_BAD_HDR   = 3'd3,
		ST_SEQ_GAP   = 3'd4,
		ST_TS_BACK   = 3'd5
	} status_t;

	typedef struct packed {
		logic        enable;
		logic [31:0] magic_word;
		logic [7:0]  version_code;
		logic [7:0]  format_code;
		logic [31:0] sample_rate;
		logic [9:0]  samples_per_frame;
		logic [15:0] silence_threshold;
	} cfg_t;

	// one queue entry: an optional sample and an optional frame summary
	typedef struct packed {
		logic               sample_vld;
		logic signed [15:0] sample;
		logic               verdict_vld;
		logic               len_ok;
		logic               hdr_ok;
		logic [31:0]        seq;
		logic [31:0]        ts;
		logic [15:0]        peak;
	} entry_t;

endpackage

// ----- rtl/afic_front.sv -----
`timescale 1ns / 1ps
module afic_front #(
	parameter int MAX_FRAME_SAMPLES = 512
) (
	input  logic            clk,
	input  logic            arst_n,
	input  afic_pkg::cfg_t  cfg,
	input  logic            accept,
	input  logic [7:0]      frame_byte,
	input  logic            last_byte,
	output logic            push,
	output afic_pkg::entry_t entry
);
	import afic_pkg::*;

	localparam int HEADER_BYTES = 24;
	localparam int PW = $clog2(HEADER_BYTES + 2 * MAX_FRAME_SAMPLES + 2);
	localparam int LW = (PW > 11) ? PW : 11;
	localparam logic [PW-1:0] HDR_END    = PW'(HEADER_BYTES);
	localparam logic [PW-1:0] SAMPLE_END = PW'(HEADER_BYTES + 2 * MAX_FRAME_SAMPLES);
	localparam logic [PW-1:0] POS_SAT    = PW'(HEADER_BYTES + 2 * MAX_FRAME_SAMPLES + 1);

	// header byte offsets that close a field
	localparam logic [4:0] OFS_MAGIC   = 5'd3;
	localparam logic [4:0] OFS_VERSION = 5'd4;
	localparam logic [4:0] OFS_FORMAT  = 5'd5;
	localparam logic [4:0] OFS_CHANNEL = 5'd6;
	localparam logic [4:0] OFS_RSVD    = 5'd7;
	localparam logic [4:0] OFS_RATE    = 5'd11;
	localparam logic [4:0] OFS_SEQ     = 5'd15;
	localparam logic [4:0] OFS_TS      = 5'd19;
	localparam logic [4:0] OFS_SPF     = 5'd23;

	logic [PW-1:0] pos_q, pos_nx;
	logic [31:0]   shift_q, shift_nx;
	logic          hdr_ok_q, hdr_ok_nx;
	logic [31:0]   seq_q, seq_nx;
	logic [31:0]   ts_q, ts_nx;
	logic [7:0]    low_q, low_nx;
	logic [15:0]   peak_q, peak_nx;
	logic [15:0]   raw;
	logic [15:0]   mag;
	logic          smp_vld;
	logic          spf_ok;
	logic          len_ok;

	// classify the byte by its offset in the frame
	always_comb begin
		shift_nx  = {frame_byte, shift_q[31:8]};
		hdr_ok_nx = hdr_ok_q;
		seq_nx    = seq_q;
		ts_nx     = ts_q;
		low_nx    = low_q;
		peak_nx   = peak_q;
		smp_vld   = 1'b0;
		raw       = {frame_byte, low_q};
		mag       = raw[15] ? 16'(-raw) : raw;
		if (pos_q < HDR_END) begin
			case (pos_q[4:0])
				OFS_MAGIC:   if (shift_nx != cfg.magic_word) hdr_ok_nx = 1'b0;
				OFS_VERSION: if (frame_byte != cfg.version_code) hdr_ok_nx = 1'b0;
				OFS_FORMAT:  if (frame_byte != cfg.format_code) hdr_ok_nx = 1'b0;
				OFS_CHANNEL: if (frame_byte != 8'd1) hdr_ok_nx = 1'b0;
				OFS_RSVD:    if (frame_byte != 8'd0) hdr_ok_nx = 1'b0;
				OFS_RATE:    if (shift_nx != cfg.sample_rate) hdr_ok_nx = 1'b0;
				OFS_SEQ:     seq_nx = shift_nx;
				OFS_TS:      ts_nx = shift_nx;
				OFS_SPF: begin
					if (shift_nx != {22'd0, cfg.samples_per_frame}) hdr_ok_nx = 1'b0;
				end
				default: ;
			endcase
		end else if (pos_q < SAMPLE_END) begin
			if (!pos_q[0]) begin
				low_nx = frame_byte;
			end else begin
				smp_vld = 1'b1;
				if (mag > peak_q) peak_nx = mag;
			end
		end
		pos_nx = (pos_q < POS_SAT) ? pos_q + PW'(1) : pos_q;
		spf_ok = (cfg.samples_per_frame != 10'd0) &&
			({22'd0, cfg.samples_per_frame} <= 32'(MAX_FRAME_SAMPLES));
		len_ok = spf_ok && (LW'(pos_nx) ==
			LW'(HEADER_BYTES) + LW'({cfg.samples_per_frame, 1'b0}));
	end

	// build the queue entry for this transaction
	always_comb begin
		push              = accept && (smp_vld || last_byte);
		entry.sample_vld  = smp_vld;
		entry.sample      = raw;
		entry.verdict_vld = last_byte;
		entry.len_ok      = len_ok;
		entry.hdr_ok      = hdr_ok_nx;
		entry.seq         = seq_nx;
		entry.ts          = ts_nx;
		entry.peak        = peak_nx;
	end

	// advance frame state, drop it after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			shift_q  <= '0;
			hdr_ok_q <= 1'b1;
			seq_q    <= '0;
			ts_q     <= '0;
			low_q    <= '0;
			peak_q   <= '0;
		end else if (accept) begin
			if (last_byte) begin
				pos_q    <= '0;
				shift_q  <= '0;
				hdr_ok_q <= 1'b1;
				seq_q    <= '0;
				ts_q     <= '0;
				low_q    <= '0;
				peak_q   <= '0;
			end else begin
				pos_q    <= pos_nx;
				shift_q  <= shift_nx;
				hdr_ok_q <= hdr_ok_nx;
				seq_q    <= seq_nx;
				ts_q     <= ts_nx;
				low_q    <= low_nx;
				peak_q   <= peak_nx;
			end
		end
	end

endmodule

// ----- rtl/afic_queue.sv -----
`timescale 1ns / 1ps
module afic_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  afic_pkg::entry_t            push_entry,
	input  logic                        pop,
	output afic_pkg::entry_t            head,
	output logic                        empty,
	output logic                        full,
	output logic [$clog2(afic_pkg::QUEUE_DEPTH):0] level
);
	import afic_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);

	entry_t        mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   level_q;

	assign empty = (level_q == '0);
	assign full  = (level_q == (AW+1)'(QUEUE_DEPTH));
	assign level = level_q;
	assign head  = mem_q[rd_ptr_q];

	// store entries
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_entry;
	end

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + AW'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + AW'(1);
			if (push && !pop) level_q <= level_q + (AW+1)'(1);
			else if (pop && !push) level_q <= level_q - (AW+1)'(1);
		end
	end

endmodule

// ----- rtl/afic_back.sv -----
`timescale 1ns / 1ps
module afic_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  afic_pkg::cfg_t                    cfg,
	input  afic_pkg::entry_t                  head,
	input  logic                              empty,
	output logic                              pop,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [afic_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                              m_tuser,
	output logic                              m_tlast
);
	import afic_pkg::*;

	logic        out_vld_q;
	logic [OUT_DATA_W-1:0] data_q;
	logic        kind_q;
	logic        last_q;
	logic        smp_done_q;
	logic [31:0] next_seq_q;
	logic [31:0] prev_ts_q;
	logic        seq_vld_q;
	logic [31:0] frame_cnt_q;
	logic [31:0] loud_cnt_q;

	status_t     status;
	logic        loud;
	logic        ok;
	logic [31:0] frame_cnt_nx;
	logic [31:0] loud_cnt_nx;
	logic        slot_free;
	logic        load;
	logic        send_smp;
	logic [OUT_DATA_W-1:0] smp_word;
	logic [OUT_DATA_W-1:0] vrd_word;

	// judge the frame at the queue head against the history
	always_comb begin
		if (!cfg.enable) status = ST_DISABLED;
		else if (!head.len_ok) status = ST_BAD_LEN;
		else if (!head.hdr_ok) status = ST_BAD_HDR;
		else if (seq_vld_q && (head.seq != next_seq_q)) status = ST_SEQ_GAP;
		else if ((prev_ts_q != '0) && (head.ts < prev_ts_q)) status = ST_TS_BACK;
		else status = ST_ACCEPTED;
		loud         = head.peak > cfg.silence_threshold;
		ok           = (status == ST_ACCEPTED);
		frame_cnt_nx = frame_cnt_q + {31'd0, ok};
		loud_cnt_nx  = loud_cnt_q + {31'd0, ok && loud};
		smp_word     = {{(OUT_DATA_W-16){1'b0}}, head.sample};
		vrd_word     = {{(OUT_DATA_W-164){1'b0}}, loud_cnt_nx, frame_cnt_nx, loud,
			head.peak, head.ts, head.seq, status, 16'd0};
	end

	// pick the next result; a head with both parts gives the sample first
	always_comb begin
		slot_free = !out_vld_q || m_tready;
		load      = slot_free && !empty;
		send_smp  = head.sample_vld && !smp_done_q;
		pop       = load && !(send_smp && head.verdict_vld);
	end

	// hold control, history and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q   <= 1'b0;
			smp_done_q  <= 1'b0;
			next_seq_q  <= '0;
			prev_ts_q   <= '0;
			seq_vld_q   <= 1'b0;
			frame_cnt_q <= '0;
			loud_cnt_q  <= '0;
		end else begin
			if (slot_free) out_vld_q <= !empty;
			if (load) begin
				if (send_smp) begin
					smp_done_q <= head.verdict_vld;
				end else begin
					smp_done_q  <= 1'b0;
					frame_cnt_q <= frame_cnt_nx;
					loud_cnt_q  <= loud_cnt_nx;
					if (ok) begin
						next_seq_q <= head.seq + 32'd1;
						prev_ts_q  <= head.ts;
						seq_vld_q  <= 1'b1;
					end
				end
			end
		end
	end

	// load the output register
	always_ff @(posedge clk) begin
		if (load) begin
			if (send_smp) begin
				data_q <= smp_word;
				kind_q <= KIND_SAMPLE;
				last_q <= 1'b0;
			end else begin
				data_q <= vrd_word;
				kind_q <= KIND_VERDICT;
				last_q <= 1'b1;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = data_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

endmodule

// ----- rtl/audio_frame_ingress_checker.sv -----
`timescale 1ns / 1ps
// Channel  Dir  Handshake         Payload
// s_*      in   s_tvalid/s_tready s_tdata[7:0] frame_byte, s_tlast last_byte
// m_*      out  m_tvalid/m_tready m_tdata results, m_tuser kind, m_tlast end_of_run
// cfg_*    in   cfg_we            cfg_index register, cfg_wdata value
//
// One byte is taken per cycle while the four-entry queue has room.
// A result is written to the queue when its byte is accepted, then loaded into the output register.
// A byte that both completes a sample and ends a frame yields two results,
// which leave the single output register one after the other, the sample first.
// Reset clears all control state and loads register defaults; no clearing pass.
// Either side may stall; the queue absorbs up to four pending entries.
module audio_frame_ingress_checker #(
	parameter int MAX_FRAME_SAMPLES = afic_pkg::MAX_FRAME_SAMPLES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] frame_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [15:0] sample, [18:16] status, [50:19] sequence_res, [82:51] frame_stamp,
	// [98:83] peak, [99] loud, [131:100] accepted_frames, [163:132] loud_frames
	output logic [afic_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic        m_tuser,   // [0] kind
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);
	import afic_pkg::*;

	typedef enum logic [2:0] {
		REG_ENABLE    = 3'd0,
		REG_MAGIC     = 3'd1,
		REG_VERSION   = 3'd2,
		REG_FORMAT    = 3'd3,
		REG_RATE      = 3'd4,
		REG_SPF       = 3'd5,
		REG_THRESHOLD = 3'd6
	} reg_idx_t;

	cfg_t   cfg_q;
	logic   accept;
	logic   push;
	entry_t push_entry;
	entry_t head;
	logic   pop;
	logic   q_empty;
	logic   q_full;
	logic [$clog2(QUEUE_DEPTH):0] q_level;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable            <= 1'b0;
			cfg_q.magic_word        <= '0;
			cfg_q.version_code      <= '0;
			cfg_q.format_code       <= '0;
			cfg_q.sample_rate       <= 32'd48000;
			cfg_q.samples_per_frame <= 10'd480;
			cfg_q.silence_threshold <= 16'd32;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ENABLE:    cfg_q.enable            <= cfg_wdata[0];
				REG_MAGIC:     cfg_q.magic_word        <= cfg_wdata;
				REG_VERSION:   cfg_q.version_code      <= cfg_wdata[7:0];
				REG_FORMAT:    cfg_q.format_code       <= cfg_wdata[7:0];
				REG_RATE:      cfg_q.sample_rate       <= cfg_wdata;
				REG_SPF:       cfg_q.samples_per_frame <= cfg_wdata[9:0];
				REG_THRESHOLD: cfg_q.silence_threshold <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	afic_front #(
		.MAX_FRAME_SAMPLES(MAX_FRAME_SAMPLES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.accept    (accept),
		.frame_byte(s_tdata),
		.last_byte (s_tlast),
		.push      (push),
		.entry     (push_entry)
	);

	afic_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full),
		.level     (q_level)
	);

	afic_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.head    (head),
		.empty   (q_empty),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	// queue never holds more than its depth
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_level <= ($clog2(QUEUE_DEPTH)+1)'(QUEUE_DEPTH))
		else $error("queue level beyond depth");

	// a sample result carries no frame end and a zero status
	a_sample_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_SAMPLE) |-> (!m_tlast && m_tdata[18:16] == 3'd0))
		else $error("sample result with verdict fields");

	// loud flag on a verdict agrees with its peak
	a_loud_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_VERDICT && $stable(cfg_q.silence_threshold)) |->
		(m_tdata[99] == (m_tdata[98:83] > cfg_q.silence_threshold)))
		else $error("loud flag disagrees with peak");

endmodule
